// File: rtl/core/calendar_day_difference_defines.svh
// Assertion macros shared by the date difference RTL.
// Depends on a clock named clock and a synchronous reset named reset in the user.
`ifndef CALENDAR_DAY_DIFFERENCE_DEFINES_SVH
`define CALENDAR_DAY_DIFFERENCE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CDD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CDD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/cdd_pkg.sv
// Types, constants and the month table of the calendar day difference block.
// No dependencies.
package cdd_pkg;

   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned HOUR_W  = 5;
   localparam int unsigned MIN_W   = 6;
   localparam int unsigned SEC_W   = 6;
   localparam int unsigned OUT_W   = 22;

   localparam int unsigned ACC_W   = 41;
   localparam int unsigned TIME_W  = 18;
   localparam int unsigned TSUM_W  = 17;
   localparam int unsigned DDAY_W  = 24;
   localparam int unsigned MOFF_W  = 9;
   localparam int unsigned Q100_W  = 8;
   localparam int unsigned Q400_W  = 6;

   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;
   localparam int DAYS_IN_YEAR  = 365;
   localparam int DAYS_MAX      = 4194303;
   localparam int MONTH_MARCH   = 3;

   localparam int RECIP_100       = 20972;
   localparam int RECIP_100_SHIFT = 21;
   localparam int RECIP_25        = 2622;
   localparam int RECIP_25_SHIFT  = 16;

   typedef struct packed {
      logic [YEAR_W-1:0]  first_year;
      logic [MONTH_W-1:0] first_month;
      logic [DAY_W-1:0]   first_day;
      logic [HOUR_W-1:0]  first_hour;
      logic [MIN_W-1:0]   first_minute;
      logic [SEC_W-1:0]   first_second;
      logic [YEAR_W-1:0]  second_year;
      logic [MONTH_W-1:0] second_month;
      logic [DAY_W-1:0]   second_day;
      logic [HOUR_W-1:0]  second_hour;
      logic [MIN_W-1:0]   second_minute;
      logic [SEC_W-1:0]   second_sec;
   } req_word_type;

   typedef struct packed {
      logic [OUT_W-1:0] days_apart;
   } rsp_word_type;

   typedef enum logic {
      DATE_SECOND,
      DATE_FIRST
   } date_type;

   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_TIME,
      STEP_PREP,
      STEP_LEAP,
      STEP_YEAR,
      STEP_CEIL4,
      STEP_CEIL100,
      STEP_CEIL400,
      STEP_MONTH,
      STEP_DAY
   } step_type;

   typedef struct packed {
      date_type date;
      step_type step;
   } term_ctrl_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] a;
      logic signed [ACC_W-1:0] b;
      logic                    sub;
   } alu_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TIME,
      ST_PREP,
      ST_LEAP,
      ST_YEAR,
      ST_CEIL4,
      ST_CEIL100,
      ST_CEIL400,
      ST_MONTH,
      ST_DAY,
      ST_MUL,
      ST_SIGN,
      ST_NEG_D,
      ST_NEG_T,
      ST_ADJ
   } state_type;

   // Days of a common year before the given month; months past December run on at 31 days.
   function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] mo);
      logic [MOFF_W-1:0] days;
      case (mo)
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         4'd13:   days = 9'd365;
         4'd14:   days = 9'd396;
         4'd15:   days = 9'd427;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// File: rtl/core/cdd_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on cdd_pkg for the word types.
interface cdd_req_if import cdd_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface cdd_rsp_if import cdd_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/cdd_alu.sv
// Shared signed adder/subtractor used by every accumulation step.
// Depends on cdd_pkg for the operand struct.
module cdd_alu import cdd_pkg::*; (
   input  alu_req_type             op,
   output logic signed [ACC_W-1:0] result
);

   assign result = op.sub ? (op.a - op.b) : (op.a + op.b);

endmodule

// File: rtl/core/cdd_term.sv
// Operand generator: year preparation registers, leap test and the term for each step.
// Depends on cdd_pkg for types, constants and the month table.
module cdd_term import cdd_pkg::*; #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  logic                    clock,
   input  req_word_type            word,
   input  term_ctrl_type           ctrl,
   output logic signed [ACC_W-1:0] term
);

   logic [YEAR_W-1:0]     sel_year;
   logic [MONTH_W-1:0]    sel_month;
   logic [DAY_W-1:0]      sel_day;
   logic [HOUR_W-1:0]     sel_hour;
   logic [MIN_W-1:0]      sel_min;
   logic [SEC_W-1:0]      sel_sec;
   logic [YEAR_W-1:0]     year_sat;
   logic [YEAR_W+14:0]    q100_prod;
   logic [YEAR_W+7:0]     q400_prod;
   logic [YEAR_W-1:0]     y_ff;
   logic [Q100_W-1:0]     q100_ff;
   logic [Q400_W-1:0]     q400_ff;
   logic                  ne100_ff;
   logic                  ne400_ff;
   logic                  ne100_in;
   logic                  ne400_in;
   logic                  leap;
   logic [YEAR_W+8:0]     year_days;
   logic [YEAR_W-2:0]     ceil4;
   logic [Q100_W:0]       ceil100;
   logic [Q400_W:0]       ceil400;
   logic [MOFF_W-1:0]     month_days;
   logic signed [DAY_W:0] day_term;
   logic [TSUM_W-1:0]     time_secs;

   always_comb begin
      if (ctrl.date == DATE_FIRST) begin
         sel_year  = word.first_year;
         sel_month = word.first_month;
         sel_day   = word.first_day;
         sel_hour  = word.first_hour;
         sel_min   = word.first_minute;
         sel_sec   = word.first_second;
      end else begin
         sel_year  = word.second_year;
         sel_month = word.second_month;
         sel_day   = word.second_day;
         sel_hour  = word.second_hour;
         sel_min   = word.second_minute;
         sel_sec   = word.second_sec;
      end
   end

   // Division by 100 and by 400 are reciprocal multiplies, exact over the 14-bit year.
   assign year_sat  = (32'(sel_year) > MAX_YEAR) ? YEAR_W'(MAX_YEAR) : sel_year;
   assign q100_prod = (YEAR_W+15)'(year_sat) * (YEAR_W+15)'(RECIP_100);
   assign q400_prod = (YEAR_W+8)'(year_sat[YEAR_W-1:4]) * (YEAR_W+8)'(RECIP_25);

   assign ne100_in = y_ff != (YEAR_W'(q100_ff) * YEAR_W'(100));
   assign ne400_in = y_ff != (YEAR_W'(q400_ff) * YEAR_W'(400));

   always_ff @(posedge clock) begin
      if (ctrl.step == STEP_PREP) begin
         y_ff    <= year_sat;
         q100_ff <= q100_prod[RECIP_100_SHIFT +: Q100_W];
         q400_ff <= q400_prod[RECIP_25_SHIFT +: Q400_W];
      end
      if (ctrl.step == STEP_LEAP) begin
         ne100_ff <= ne100_in;
         ne400_ff <= ne400_in;
      end
   end

   assign leap       = ((y_ff[1:0] == 2'b00) && ne100_ff) || !ne400_ff;
   assign year_days  = (YEAR_W+9)'(y_ff) * (YEAR_W+9)'(DAYS_IN_YEAR);
   assign ceil4      = {1'b0, y_ff[YEAR_W-1:2]} + (YEAR_W-1)'(|y_ff[1:0]);
   assign ceil100    = {1'b0, q100_ff} + (Q100_W+1)'(ne100_ff);
   assign ceil400    = {1'b0, q400_ff} + (Q400_W+1)'(ne400_ff);
   assign month_days = month_offset(sel_month)
                     + MOFF_W'(leap && (sel_month >= MONTH_W'(MONTH_MARCH)));
   assign day_term   = $signed({1'b0, sel_day}) - (DAY_W+1)'(1);
   assign time_secs  = TSUM_W'(sel_hour) * TSUM_W'(SECS_PER_HOUR)
                     + TSUM_W'(sel_min) * TSUM_W'(SECS_PER_MIN)
                     + TSUM_W'(sel_sec);

   always_comb begin
      case (ctrl.step)
         STEP_TIME:    term = $signed(ACC_W'(time_secs));
         STEP_YEAR:    term = $signed(ACC_W'(year_days));
         STEP_CEIL4:   term = $signed(ACC_W'(ceil4));
         STEP_CEIL100: term = -$signed(ACC_W'(ceil100));
         STEP_CEIL400: term = $signed(ACC_W'(ceil400));
         STEP_MONTH:   term = $signed(ACC_W'(month_days));
         STEP_DAY:     term = ACC_W'(day_term);
         default:      term = '0;
      endcase
   end

endmodule

// File: rtl/core/calendar_day_difference.sv
// Top level of the calendar day difference block: sequencer, accumulator and output register.
// Depends on cdd_pkg, cdd_if, cdd_alu, cdd_term and calendar_day_difference_defines.svh.
`include "calendar_day_difference_defines.svh"

// Each request word carries two proleptic Gregorian date-times; the response word gives the
// absolute number of whole days between them, truncated, saturating at 4194303. Years above
// MAX_YEAR are taken as MAX_YEAR. A word is accepted only while the sequencer is idle, so a new
// word is taken only after the last one has left the final rounding step. The sequencer runs
// two time terms, eight year, leap and month steps per date, then the scale, sign, negation and
// final rounding steps; every sum among them goes through the single shared adder. Rounding
// waits while an earlier response is pending. A finished response waits in its own register,
// so the next word is accepted while it is still pending.
module calendar_day_difference import cdd_pkg::*; #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input logic       clock,
   input logic       reset,
   cdd_req_if.sink   req_if,
   cdd_rsp_if.source rsp_if
);

   state_type                state_ff, state_in;
   date_type                 date_ff, date_in;
   req_word_type             word_ff, word_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  prod_ff, prod_in;
   logic signed [TIME_W-1:0] t_ff, t_in;
   logic signed [DDAY_W-1:0] d_ff, d_in;
   logic                     neg_ff, neg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_word_type             rsp_data_ff, rsp_data_in;

   term_ctrl_type              ctrl;
   alu_req_type                alu_op;
   logic signed [ACC_W-1:0]    alu_res;
   logic signed [ACC_W-1:0]    term;
   logic signed [DDAY_W+17:0]  mul_full;
   logic signed [2:0]          qadj;

   cdd_term #(
      .MAX_YEAR (MAX_YEAR)
   ) u_term (
      .clock (clock),
      .word  (word_ff),
      .ctrl  (ctrl),
      .term  (term)
   );

   cdd_alu u_alu (
      .op     (alu_op),
      .result (alu_res)
   );

   assign mul_full = $signed(acc_ff[DDAY_W-1:0]) * $signed(18'(SECS_PER_DAY));

   // Floor of the leftover seconds over one day; they never reach minus two days.
   always_comb begin
      if (t_ff >= TIME_W'(SECS_PER_DAY)) begin
         qadj = 3'sd1;
      end else if (t_ff >= TIME_W'(0)) begin
         qadj = 3'sd0;
      end else if (t_ff >= TIME_W'(-SECS_PER_DAY)) begin
         qadj = -3'sd1;
      end else begin
         qadj = -3'sd2;
      end
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      date_in      = date_ff;
      word_in      = word_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      t_in         = t_ff;
      d_in         = d_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ctrl.date    = date_ff;
      ctrl.step    = STEP_NONE;
      alu_op.a     = acc_ff;
      alu_op.b     = term;
      alu_op.sub   = (date_ff == DATE_FIRST);

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               word_in  = req_if.data;
               acc_in   = '0;
               date_in  = DATE_SECOND;
               state_in = ST_TIME;
            end
         end
         ST_TIME: begin
            ctrl.step = STEP_TIME;
            if (date_ff == DATE_SECOND) begin
               acc_in  = alu_res;
               date_in = DATE_FIRST;
            end else begin
               t_in     = TIME_W'(alu_res);
               acc_in   = '0;
               date_in  = DATE_SECOND;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            ctrl.step = STEP_PREP;
            state_in  = ST_LEAP;
         end
         ST_LEAP: begin
            ctrl.step = STEP_LEAP;
            state_in  = ST_YEAR;
         end
         ST_YEAR: begin
            ctrl.step = STEP_YEAR;
            acc_in    = alu_res;
            state_in  = ST_CEIL4;
         end
         ST_CEIL4: begin
            ctrl.step = STEP_CEIL4;
            acc_in    = alu_res;
            state_in  = ST_CEIL100;
         end
         ST_CEIL100: begin
            ctrl.step = STEP_CEIL100;
            acc_in    = alu_res;
            state_in  = ST_CEIL400;
         end
         ST_CEIL400: begin
            ctrl.step = STEP_CEIL400;
            acc_in    = alu_res;
            state_in  = ST_MONTH;
         end
         ST_MONTH: begin
            ctrl.step = STEP_MONTH;
            acc_in    = alu_res;
            state_in  = ST_DAY;
         end
         ST_DAY: begin
            ctrl.step = STEP_DAY;
            acc_in    = alu_res;
            if (date_ff == DATE_SECOND) begin
               date_in  = DATE_FIRST;
               state_in = ST_PREP;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = ACC_W'(mul_full);
            d_in     = acc_ff[DDAY_W-1:0];
            state_in = ST_SIGN;
         end
         ST_SIGN: begin
            alu_op.a   = prod_ff;
            alu_op.b   = ACC_W'(t_ff);
            alu_op.sub = 1'b0;
            neg_in     = alu_res[ACC_W-1];
            state_in   = ST_NEG_D;
         end
         ST_NEG_D: begin
            alu_op.a   = '0;
            alu_op.b   = ACC_W'(d_ff);
            alu_op.sub = 1'b1;
            if (neg_ff) begin
               d_in = DDAY_W'(alu_res);
            end
            state_in = ST_NEG_T;
         end
         ST_NEG_T: begin
            alu_op.a   = '0;
            alu_op.b   = ACC_W'(t_ff);
            alu_op.sub = 1'b1;
            if (neg_ff) begin
               t_in = TIME_W'(alu_res);
            end
            state_in = ST_ADJ;
         end
         ST_ADJ: begin
            alu_op.a   = ACC_W'(d_ff);
            alu_op.b   = ACC_W'(qadj);
            alu_op.sub = 1'b0;
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               if (alu_res > ACC_W'(DAYS_MAX)) begin
                  rsp_data_in.days_apart = OUT_W'(DAYS_MAX);
               end else begin
                  rsp_data_in.days_apart = OUT_W'(alu_res);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         date_ff      <= DATE_SECOND;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         date_ff      <= date_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      t_ff        <= t_in;
      d_ff        <= d_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   `CDD_ASSERT_NEXT(a_accept_starts, req_if.valid && req_if.ready, (state_ff == ST_TIME) && (date_ff == DATE_SECOND), "accepted word did not start the time pass")
   `CDD_ASSERT_NOW(a_mul_after_both, state_ff == ST_MUL, date_ff == DATE_FIRST, "day count scaled before both dates were summed")
   `CDD_ASSERT_NOW(a_adj_nonneg, state_ff == ST_ADJ, !alu_res[ACC_W-1], "day magnitude came out negative")
   `CDD_ASSERT_NOW(a_rsp_from_adj, $rose(rsp_valid_ff), $past(state_ff == ST_ADJ), "response raised outside the final step")

endmodule

// File: test/calendar_day_difference_checker.sv
// Checker for the calendar day difference block: predicts the day count of every request
// word and compares it with the response words in order.
// Depends on cdd_pkg and the channel interfaces in cdd_if.
module calendar_day_difference_checker import cdd_pkg::*; #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  logic clock,
   input  logic reset,
   cdd_req_if   req,
   cdd_rsp_if   rsp,
   output int   failures,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint FEBRUARY  = 2;
   localparam longint APRIL     = 4;
   localparam longint JUNE      = 6;
   localparam longint SEPTEMBER = 9;
   localparam longint NOVEMBER  = 11;

   typedef struct {
      req_word_type      word;
      logic [OUT_W-1:0]  days;
   } pending_type;

   pending_type expected_days[$];
   int mismatch_count = 0;

   assign failures = mismatch_count;

   function automatic bit is_leap(input longint y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
   endfunction

   function automatic longint month_days(input longint m, input longint y);
      if (m == FEBRUARY) begin
         return is_leap(y) ? 29 : 28;
      end
      if (m == APRIL || m == JUNE || m == SEPTEMBER || m == NOVEMBER) begin
         return 30;
      end
      return 31;
   endfunction

   // Months past December keep adding 31 days each.
   function automatic longint seconds_from_year_zero(
      input logic [YEAR_W-1:0]  yr,
      input logic [MONTH_W-1:0] mo,
      input logic [DAY_W-1:0]   dy,
      input logic [HOUR_W-1:0]  hr,
      input logic [MIN_W-1:0]   mi,
      input logic [SEC_W-1:0]   se
   );
      longint y;
      longint days;
      y = longint'(yr);
      if (y > longint'(MAX_YEAR)) begin
         y = longint'(MAX_YEAR);
      end
      days = y * DAYS_IN_YEAR + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      for (longint m = 1; m < longint'(mo); m++) begin
         days += month_days(m, y);
      end
      days += longint'(dy) - 1;
      return days * SECS_PER_DAY + longint'(hr) * SECS_PER_HOUR
           + longint'(mi) * SECS_PER_MIN + longint'(se);
   endfunction

   function automatic logic [OUT_W-1:0] days_between(input req_word_type w);
      longint a;
      longint b;
      longint d;
      a = seconds_from_year_zero(w.first_year, w.first_month, w.first_day,
                                 w.first_hour, w.first_minute, w.first_second);
      b = seconds_from_year_zero(w.second_year, w.second_month, w.second_day,
                                 w.second_hour, w.second_minute, w.second_sec);
      d = (b - a) / SECS_PER_DAY;
      if (d < 0) begin
         d = -d;
      end
      if (d > longint'(DAYS_MAX)) begin
         d = longint'(DAYS_MAX);
      end
      return d[OUT_W-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $realtime, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      pending_type entry;
      if (!reset) begin
         if (req.valid && req.ready) begin
            entry.word = req.data;
            entry.days = days_between(req.data);
            expected_days.push_back(entry);
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_days.size() == 0) begin
               report_mismatch($sformatf("days_apart %0d with no request pending",
                                         rsp.data.days_apart));
            end else begin
               entry = expected_days.pop_front();
               if (rsp.data.days_apart !== entry.days) begin
                  report_mismatch($sformatf("days_apart %0d, predicted %0d for word %h",
                                            rsp.data.days_apart, entry.days, entry.word));
               end
            end
         end
      end
      outstanding <= expected_days.size();
   end

endmodule

// File: test/tb.sv
// Top of the calendar day difference testbench: clock, reset, request and response traffic
// with random gaps, and the final verdict.
// Depends on cdd_pkg, cdd_if, the block and calendar_day_difference_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cdd_pkg::*;

   localparam int unsigned YEAR_CAP = 9999;
   localparam int RANDOM_ITEMS  = 1700;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 40;

   logic clock;
   logic reset;
   int   failures;
   int   outstanding;
   bit   hold_requested = 1'b0;
   int   quiet_sends = 0;

   cdd_req_if req_ch ();
   cdd_rsp_if rsp_ch ();

   calendar_day_difference #(.MAX_YEAR(YEAR_CAP)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   calendar_day_difference_checker #(.MAX_YEAR(YEAR_CAP)) day_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic req_word_type make_word(
      input int unsigned y1, mo1, d1, h1, mi1, s1,
      input int unsigned y2, mo2, d2, h2, mi2, s2
   );
      req_word_type w;
      w.first_year    = YEAR_W'(y1);
      w.first_month   = MONTH_W'(mo1);
      w.first_day     = DAY_W'(d1);
      w.first_hour    = HOUR_W'(h1);
      w.first_minute  = MIN_W'(mi1);
      w.first_second  = SEC_W'(s1);
      w.second_year   = YEAR_W'(y2);
      w.second_month  = MONTH_W'(mo2);
      w.second_day    = DAY_W'(d2);
      w.second_hour   = HOUR_W'(h2);
      w.second_minute = MIN_W'(mi2);
      w.second_sec    = SEC_W'(s2);
      return w;
   endfunction

   function automatic int unsigned pick_day(input int unsigned mo);
      int unsigned last;
      last = (mo == 2) ? 29 : ((mo == 4 || mo == 6 || mo == 9 || mo == 11) ? 30 : 31);
      return $urandom_range(1, last);
   endfunction

   function automatic int unsigned pick_year();
      if ($urandom_range(0, 7) == 0) begin
         return $urandom_range(9980, 9999);
      end
      return $urandom_range(0, 9999);
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      int kind;
      int unsigned y1, mo1, y2, mo2;
      int near_year;
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
         w.first_year    = YEAR_W'($urandom);
         w.first_month   = MONTH_W'($urandom);
         w.first_day     = DAY_W'($urandom);
         w.first_hour    = HOUR_W'($urandom);
         w.first_minute  = MIN_W'($urandom);
         w.first_second  = SEC_W'($urandom);
         w.second_year   = YEAR_W'($urandom);
         w.second_month  = MONTH_W'($urandom);
         w.second_day    = DAY_W'($urandom);
         w.second_hour   = HOUR_W'($urandom);
         w.second_minute = MIN_W'($urandom);
         w.second_sec    = SEC_W'($urandom);
         return w;
      end
      y1  = pick_year();
      mo1 = $urandom_range(1, 12);
      mo2 = $urandom_range(1, 12);
      if (kind < 60) begin
         y2 = pick_year();
      end else begin
         // Nearby dates exercise the truncation of partial days.
         near_year = int'(y1) + int'($urandom_range(0, 2)) - 1;
         if (near_year < 0) begin
            near_year = 0;
         end
         if (near_year > int'(YEAR_CAP)) begin
            near_year = int'(YEAR_CAP);
         end
         y2 = int'(near_year);
         if ($urandom_range(0, 1) == 0) begin
            mo2 = mo1;
         end
      end
      return make_word(y1, mo1, pick_day(mo1), $urandom_range(0, 23), $urandom_range(0, 59),
                       $urandom_range(0, 59), y2, mo2, pick_day(mo2), $urandom_range(0, 23),
                       $urandom_range(0, 59), $urandom_range(0, 59));
   endfunction

   task automatic send_word(input req_word_type w);
      int gap;
      if (quiet_sends > 0) begin
         gap = 0;
         quiet_sends--;
      end else begin
         gap = $urandom_range(0, 4);
         if ($urandom_range(0, 19) == 0) begin
            quiet_sends = $urandom_range(10, 40);
         end
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   initial begin : receiver
      int stall;
      int quiet;
      quiet = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_requested) begin
            stall = HOLD_CYCLES;
            hold_requested = 1'b0;
         end else if (quiet > 0) begin
            stall = 0;
            quiet--;
         end else begin
            stall = $urandom_range(0, 4);
            if ($urandom_range(0, 19) == 0) begin
               quiet = $urandom_range(10, 40);
            end
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   initial begin : stimulus
      int waited;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      rsp_ch.ready <= 1'b0;
      reset        <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_word(make_word(0, 1, 1, 0, 0, 0, 0, 1, 1, 0, 0, 0));
      send_word(make_word(16383, 15, 31, 31, 63, 63, 0, 0, 0, 0, 0, 0));
      send_word(make_word(0, 0, 0, 0, 0, 0, 16383, 15, 31, 31, 63, 63));
      send_word(make_word(0, 1, 1, 0, 0, 0, 9999, 12, 31, 23, 59, 59));
      send_word(make_word(9999, 12, 31, 23, 59, 59, 0, 1, 1, 0, 0, 0));
      send_word(make_word(10000, 6, 15, 12, 0, 0, 9999, 6, 15, 12, 0, 0));
      send_word(make_word(0, 0, 1, 0, 0, 0, 0, 1, 1, 0, 0, 0));
      send_word(make_word(2023, 13, 1, 0, 0, 0, 2023, 12, 1, 0, 0, 0));
      send_word(make_word(2023, 14, 1, 0, 0, 0, 2023, 12, 1, 0, 0, 0));
      send_word(make_word(2024, 15, 1, 0, 0, 0, 2024, 12, 1, 0, 0, 0));
      send_word(make_word(2023, 3, 0, 0, 0, 0, 2023, 2, 28, 0, 0, 0));
      send_word(make_word(2023, 5, 10, 31, 63, 63, 2023, 5, 10, 0, 0, 0));
      send_word(make_word(2000, 2, 29, 0, 0, 0, 2000, 3, 1, 0, 0, 0));
      send_word(make_word(1900, 2, 28, 0, 0, 0, 1900, 3, 1, 0, 0, 0));
      send_word(make_word(2100, 2, 28, 0, 0, 0, 2100, 3, 1, 0, 0, 0));
      send_word(make_word(2024, 1, 1, 0, 0, 0, 2025, 1, 1, 0, 0, 0));
      send_word(make_word(0, 2, 29, 0, 0, 0, 0, 3, 1, 0, 0, 0));
      send_word(make_word(2023, 7, 4, 12, 0, 0, 2023, 7, 5, 11, 59, 59));
      send_word(make_word(2023, 7, 5, 11, 59, 59, 2023, 7, 4, 12, 0, 0));
      send_word(make_word(2023, 7, 4, 12, 0, 0, 2023, 7, 5, 12, 0, 0));
      send_word(make_word(2023, 7, 5, 12, 0, 0, 2023, 7, 4, 12, 0, 0));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) begin
            hold_requested = 1'b1;
         end
         send_word(random_word());
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      waited = 0;
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (outstanding != 0) begin
         $display("Test completed with failures");
      end else begin
         repeat (SETTLE_CYCLES) @(posedge clock);
         if (failures == 0 && outstanding == 0) begin
            $display("Test completed successfully");
         end else begin
            $display("Test completed with failures");
         end
      end
      $finish;
   end

endmodule
